FILE: rtl/b64d_pkg.sv
// Shared types and constants for the streaming Base64 decoder.
// Used by the front end, the back end and the top level; depends on nothing.
package b64d_pkg;

  // One request on the input channel
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  // One result on the output channel
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        is_status;
    logic        decode_ok;
    logic [23:0] byte_count;
  } out_item_t;

  // Token classes handed from the front end to the back end
  localparam logic [1:0] TK_SEXTET = 2'd0;
  localparam logic [1:0] TK_PAD    = 2'd1;
  localparam logic [1:0] TK_BAD    = 2'd2;
  localparam logic [1:0] TK_EOT    = 2'd3;

  // Classified character
  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] value;
  } token_t;

  // Padding states
  localparam logic [1:0] PAD_NONE = 2'd0;
  localparam logic [1:0] PAD_WAIT = 2'd1;
  localparam logic [1:0] PAD_DONE = 2'd2;

  localparam logic [7:0] PAD_CHAR   = 8'h3d;
  localparam logic [5:0] LOW4_MASK  = 6'h0f;
  localparam logic [5:0] LOW2_MASK  = 6'h03;

endpackage

FILE: rtl/b64d_fifo.sv
// Two-entry queue used between front and back end and at the output.
// Generic payload width; no package dependency.
module b64d_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

FILE: rtl/b64d_front.sv
// Front end: classifies each incoming character into a token.
// Whitespace is dropped here. Depends on b64d_pkg.
module b64d_front (
  input  logic               in_push,
  input  b64d_pkg::in_item_t in_item,
  input  logic               tok_full,
  output logic               tok_push,
  output b64d_pkg::token_t   tok
);

  logic [7:0] c;
  logic       blank;
  logic [7:0] v8;
  logic [1:0] kind;

  assign c = in_item.char_code;

  // Space, tab, LF, VT, FF, CR
  assign blank = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);

  // Alphabet lookup
  always_comb begin
    v8   = 8'd0;
    kind = b64d_pkg::TK_SEXTET;
    if (in_item.end_of_text) begin
      kind = b64d_pkg::TK_EOT;
    end else if (c == b64d_pkg::PAD_CHAR) begin
      kind = b64d_pkg::TK_PAD;
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      v8 = c - 8'd65;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      v8 = c - 8'd71;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v8 = c + 8'd4;
    end else if (c == 8'h2b) begin
      v8 = 8'd62;
    end else if (c == 8'h2f) begin
      v8 = 8'd63;
    end else begin
      kind = b64d_pkg::TK_BAD;
    end
  end

  assign tok.kind  = kind;
  assign tok.value = v8[5:0];
  assign tok_push  = in_push && !tok_full && (in_item.end_of_text || !blank);

endmodule

FILE: rtl/b64d_back.sv
// Back end: group phase, padding checks, byte assembly and counting.
// Depends on b64d_pkg.
module b64d_back #(
  parameter int COUNT_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tok_valid,
  input  b64d_pkg::token_t    tok,
  output logic                tok_pop,
  input  logic                res_full,
  output logic                res_push,
  output b64d_pkg::out_item_t res
);

  logic [1:0]            phase_r, phase_nxt;
  logic [1:0]            pad_r, pad_nxt;
  logic                  err_r, err_nxt;
  logic [7:0]            part_r, part_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [COUNT_BITS+23:0] cnt_ext;
  logic [COUNT_BITS+23:0] cnt_cur_ext;
  logic                  emit_byte, emit_stat, ok;
  logic [7:0]            byte_val;
  logic [5:0]            v;
  logic [5:0]            v_lo4, v_lo2;

  assign tok_pop     = tok_valid && !res_full;
  assign v           = tok.value;
  assign v_lo4       = v & b64d_pkg::LOW4_MASK;
  assign v_lo2       = v & b64d_pkg::LOW2_MASK;
  assign cnt_ext     = {24'd0, cnt_nxt};
  assign cnt_cur_ext = {24'd0, cnt_r};

  // Next-state decode for one token
  always_comb begin
    phase_nxt = phase_r;
    pad_nxt   = pad_r;
    err_nxt   = err_r;
    part_nxt  = part_r;
    cnt_nxt   = cnt_r;
    emit_byte = 1'b0;
    emit_stat = 1'b0;
    byte_val  = 8'd0;
    ok        = !err_r && (pad_r != b64d_pkg::PAD_WAIT) &&
                !(pad_r == b64d_pkg::PAD_NONE && phase_r != 2'd0);
    if (tok.kind == b64d_pkg::TK_EOT) begin
      emit_stat = 1'b1;
      phase_nxt = 2'd0;
      pad_nxt   = b64d_pkg::PAD_NONE;
      err_nxt   = 1'b0;
      part_nxt  = 8'd0;
      cnt_nxt   = '0;
    end else if (err_r) begin
      // ignore everything until the end marker
    end else if (pad_r != b64d_pkg::PAD_NONE) begin
      if (pad_r == b64d_pkg::PAD_WAIT && tok.kind == b64d_pkg::TK_PAD) begin
        pad_nxt = b64d_pkg::PAD_DONE;
      end else begin
        err_nxt = 1'b1;
      end
    end else if (tok.kind == b64d_pkg::TK_PAD) begin
      if (phase_r < 2'd2 || part_r != 8'd0) begin
        err_nxt = 1'b1;
      end else begin
        pad_nxt = (phase_r == 2'd2) ? b64d_pkg::PAD_WAIT : b64d_pkg::PAD_DONE;
      end
    end else if (tok.kind == b64d_pkg::TK_BAD) begin
      err_nxt = 1'b1;
    end else begin
      case (phase_r)
        2'd0: begin
          part_nxt  = {v, 2'b00};
          phase_nxt = 2'd1;
        end
        2'd1: begin
          byte_val  = part_r | {6'd0, v[5:4]};
          part_nxt  = {v_lo4[3:0], 4'd0};
          phase_nxt = 2'd2;
          emit_byte = 1'b1;
        end
        2'd2: begin
          byte_val  = part_r | {4'd0, v[5:2]};
          part_nxt  = {v_lo2[1:0], 6'd0};
          phase_nxt = 2'd3;
          emit_byte = 1'b1;
        end
        default: begin
          byte_val  = part_r | {2'd0, v};
          part_nxt  = 8'd0;
          phase_nxt = 2'd0;
          emit_byte = 1'b1;
        end
      endcase
      // saturating byte count
      if (emit_byte && cnt_r != {COUNT_BITS{1'b1}}) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // Result formatting
  always_comb begin
    res.data_byte  = byte_val;
    res.is_status  = emit_stat;
    res.decode_ok  = emit_stat && ok;
    res.byte_count = emit_stat ? cnt_cur_ext[23:0] : cnt_ext[23:0];
  end

  assign res_push = tok_pop && (emit_byte || emit_stat);

  // Decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      pad_r   <= b64d_pkg::PAD_NONE;
      err_r   <= 1'b0;
      part_r  <= 8'd0;
      cnt_r   <= '0;
    end else if (tok_pop) begin
      phase_r <= phase_nxt;
      pad_r   <= pad_nxt;
      err_r   <= err_nxt;
      part_r  <= part_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/base64_decoder_checked.sv
// Top level of the streaming Base64 decoder with strict padding checks.
// Depends on b64d_pkg, b64d_fifo, b64d_front and b64d_back.
//
// Usage:
//  - Input channel: drive in_item with one character (or end_of_text = 1)
//    and raise in_push; the request is taken on a clock edge where in_full
//    is low. Whitespace is dropped on entry and causes no result.
//  - Output channel: while out_empty is low, out_item holds the oldest
//    result; raise out_pop to take it. A result is either a decoded byte
//    (is_status = 0) or the end-of-string status with ok flag and count.
//  - Path: the accepting edge writes the token queue; a later edge passes the
//    token through the decode stage into the output queue, once that queue
//    has room.
//  - Throughput: one character per cycle while out_pop keeps taking results;
//    the decode stage and the two-entry queues on each side set this rate.
//  - Stall: when out_pop stays low the output queue fills, the decode stage
//    halts, the token queue fills and in_full rises; no request is lost.
//  - Reset (rst_n low, synchronous) empties both queues and clears phase,
//    padding state, error flag, partial byte and byte count.
module base64_decoder_checked #(
  parameter int COUNT_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  b64d_pkg::in_item_t  in_item,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output b64d_pkg::out_item_t out_item
);

  localparam int TW = $bits(b64d_pkg::token_t);
  localparam int OW = $bits(b64d_pkg::out_item_t);

  logic                tok_push, tok_full, tok_empty, tok_pop;
  b64d_pkg::token_t    tok_in, tok_out;
  logic                res_push, res_full;
  b64d_pkg::out_item_t res;

  // Character classification
  b64d_front u_front (
    .in_push  (in_push),
    .in_item  (in_item),
    .tok_full (tok_full),
    .tok_push (tok_push),
    .tok      (tok_in)
  );

  assign in_full = tok_full;

  // Queue between front and back end
  b64d_fifo #(.W(TW)) u_tok_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (tok_push),
    .wdata (tok_in),
    .full  (tok_full),
    .pop   (tok_pop),
    .rdata (tok_out),
    .empty (tok_empty)
  );

  // Decode stage
  b64d_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (!tok_empty),
    .tok       (tok_out),
    .tok_pop   (tok_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Result queue
  b64d_fifo #(.W(OW)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

endmodule

FILE: dv/tb_base64_decoder_checked.sv
`timescale 1ns / 1ps
// Self-checking testbench for base64_decoder_checked: directed padding and error
// cases, then random encoded strings under shifting idle and stall patterns.
// Depends on b64d_pkg and the base64_decoder_checked RTL.
module tb_base64_decoder_checked;

  localparam int COUNT_BITS   = 24;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam string B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                in_push  = 1'b0;
  b64d_pkg::in_item_t  in_item  = '0;
  logic                in_full;
  logic                out_empty;
  logic                out_pop  = 1'b0;
  b64d_pkg::out_item_t out_item;

  base64_decoder_checked #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // Decoder state as the stream has seen it so far
  logic [1:0]            grp_phase  = '0;
  logic [1:0]            pad_state  = b64d_pkg::PAD_NONE;
  bit                    fmt_error  = 1'b0;
  logic [7:0]            hi_bits    = '0;
  logic [COUNT_BITS-1:0] byte_total = '0;

  b64d_pkg::out_item_t decoded_q[$];

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_reqs      = 0;
  int hold_acks      = 0;
  int hold_left      = 0;
  int mismatch_count = 0;
  int outputs_checked = 0;
  int strings_ok     = 0;
  int strings_bad    = 0;
  int cycle_count    = 0;

  function automatic bit is_space(input logic [7:0] c);
    // space, or tab through carriage return
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic bit sextet_value(input logic [7:0] c, output logic [5:0] v);
    v = '0;
    for (int i = 0; i < 64; i++) begin
      if (B64_ALPHABET[i] == c) begin
        v = 6'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] random_blank();
    return ($urandom_range(5) == 0) ? 8'h20 : 8'(8'h09 + $urandom_range(4));
  endfunction

  // Advance the decoder by one request; returns 1 when it yields an output
  function automatic bit decode_char(input b64d_pkg::in_item_t req,
                                     output b64d_pkg::out_item_t res);
    logic [5:0] v;
    logic [7:0] b;
    res = '0;
    if (req.end_of_text) begin
      res.is_status  = 1'b1;
      res.decode_ok  = !fmt_error && pad_state != b64d_pkg::PAD_WAIT &&
                       !(pad_state == b64d_pkg::PAD_NONE && grp_phase != 2'd0);
      res.byte_count = byte_total[23:0];
      grp_phase  = '0;
      pad_state  = b64d_pkg::PAD_NONE;
      fmt_error  = 1'b0;
      hi_bits    = '0;
      byte_total = '0;
      return 1'b1;
    end
    if (fmt_error || is_space(req.char_code)) return 1'b0;
    // inside padding only the second pad of a pair is legal
    if (pad_state != b64d_pkg::PAD_NONE) begin
      if (pad_state == b64d_pkg::PAD_WAIT && req.char_code == b64d_pkg::PAD_CHAR)
        pad_state = b64d_pkg::PAD_DONE;
      else fmt_error = 1'b1;
      return 1'b0;
    end
    if (req.char_code == b64d_pkg::PAD_CHAR) begin
      if (grp_phase < 2'd2 || hi_bits != 8'h00) fmt_error = 1'b1;
      else pad_state = (grp_phase == 2'd2) ? b64d_pkg::PAD_WAIT : b64d_pkg::PAD_DONE;
      return 1'b0;
    end
    if (!sextet_value(req.char_code, v)) begin
      fmt_error = 1'b1;
      return 1'b0;
    end
    case (grp_phase)
      2'd0: begin
        hi_bits   = {v, 2'b00};
        grp_phase = 2'd1;
        return 1'b0;
      end
      2'd1: begin
        b         = hi_bits | {6'b0, v[5:4]};
        hi_bits   = {v[3:0], 4'b0};
        grp_phase = 2'd2;
      end
      2'd2: begin
        b         = hi_bits | {4'b0, v[5:2]};
        hi_bits   = {v[1:0], 6'b0};
        grp_phase = 2'd3;
      end
      default: begin
        b         = hi_bits | {2'b0, v};
        hi_bits   = '0;
        grp_phase = 2'd0;
      end
    endcase
    if (byte_total != '1) byte_total++;
    res.data_byte  = b;
    res.byte_count = byte_total[23:0];
    return 1'b1;
  endfunction

  // Offer one request, idling on a share of the cycles, and wait until it is taken
  task automatic send_request(input b64d_pkg::in_item_t req);
    b64d_pkg::out_item_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (decode_char(req, res)) decoded_q.push_back(res);
  endtask

  task automatic send_char(input logic [7:0] c);
    b64d_pkg::in_item_t req;
    req.char_code   = c;
    req.end_of_text = 1'b0;
    send_request(req);
  endtask

  task automatic send_end();
    b64d_pkg::in_item_t req;
    req.char_code   = 8'($urandom_range(255));
    req.end_of_text = 1'b1;
    send_request(req);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic pause_until_drained();
    in_push <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  // Encode random bytes, maybe damage the text, sprinkle blanks, then end it
  task automatic send_random_string(input int corrupt_pct, inout int items);
    logic [7:0]  raw[$];
    logic [7:0]  txt[$];
    logic [7:0]  c;
    logic [5:0]  v;
    logic [23:0] w;
    int          n_raw;
    int          left;
    int          pos;
    n_raw = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(8);
    repeat (n_raw) raw.push_back(8'($urandom_range(255)));
    for (int i = 0; i < n_raw; i += 3) begin
      left = n_raw - i;
      w = {raw[i], (left > 1) ? raw[i+1] : 8'h00, (left > 2) ? raw[i+2] : 8'h00};
      txt.push_back(B64_ALPHABET[w[23:18]]);
      txt.push_back(B64_ALPHABET[w[17:12]]);
      txt.push_back((left > 1) ? B64_ALPHABET[w[11:6]] : b64d_pkg::PAD_CHAR);
      txt.push_back((left > 2) ? B64_ALPHABET[w[5:0]] : b64d_pkg::PAD_CHAR);
    end
    if ($urandom_range(99) < corrupt_pct) begin
      case ($urandom_range(5))
        0: begin  // foreign character somewhere
          do c = 8'($urandom_range(255));
          while (is_space(c) || c == b64d_pkg::PAD_CHAR || sextet_value(c, v));
          txt.insert($urandom_range(txt.size()), c);
        end
        1: begin  // cut short
          repeat ($urandom_range(1, 2)) if (txt.size() > 0) void'(txt.pop_back());
        end
        2: begin  // junk after the end
          c = $urandom_range(1) ? b64d_pkg::PAD_CHAR
                                : 8'(B64_ALPHABET[$urandom_range(63)]);
          txt.push_back(c);
        end
        3: begin  // stray pad
          txt.insert($urandom_range(txt.size()), b64d_pkg::PAD_CHAR);
        end
        4: begin  // change the last data character before the padding
          pos = txt.size() - 1;
          while (pos >= 0 && txt[pos] == b64d_pkg::PAD_CHAR) pos--;
          if (pos >= 0 && pos < txt.size() - 1) txt[pos] = B64_ALPHABET[$urandom_range(63)];
        end
        default: begin  // lose or spoil the final pad
          if (txt.size() > 0 && txt[txt.size()-1] == b64d_pkg::PAD_CHAR) begin
            if ($urandom_range(1)) void'(txt.pop_back());
            else txt[txt.size()-1] = B64_ALPHABET[$urandom_range(63)];
          end
        end
      endcase
    end
    foreach (txt[i]) begin
      if ($urandom_range(9) == 0) send_char(random_blank());
      send_char(txt[i]);
      items++;
    end
    if ($urandom_range(7) == 0) send_char(random_blank());
    send_end();
    items++;
  endtask

  // Unstructured characters over the whole code range
  task automatic send_noise(inout int items);
    logic [7:0] c;
    repeat ($urandom_range(1, 8)) begin
      c = ($urandom_range(4) == 0) ? 8'(B64_ALPHABET[$urandom_range(63)])
                                   : 8'($urandom_range(255));
      send_char(c);
      if (!is_space(c)) items++;
    end
    send_end();
    items++;
  endtask

  task automatic test_padding_rules();
    send_text("//8=");  send_end();  // all-ones bytes, single pad closes group
    send_text("QQ=\t="); send_end(); // pad pair split by a blank
    send_text("QQ=");   send_end();  // end while second pad still owed
    send_text("QR==");  send_end();  // leftover bits not zero
    send_text("=");     send_end();  // pad at group start
    send_text("QQ==Q"); send_end();  // text after padding
  endtask

  task automatic test_invalid_input();
    // zero and top codes are foreign; the rest of the string is ignored
    send_char("A"); send_char(8'h00); send_char(8'hff); send_end();
    // unfinished group still reports the byte it produced
    send_text("QU"); send_end();
  endtask

  task automatic test_random_traffic(input int s_pct, input int r_pct, input int target);
    int items = 0;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (items < target) begin
      if ($urandom_range(9) == 0) send_noise(items);
      else send_random_string(25, items);
    end
  endtask

  // Output side holds off while input keeps coming, so in_full rises
  task automatic test_output_stall();
    int items = 0;
    send_idle_pct = 0;
    hold_reqs <= hold_reqs + 1;
    while (items < 40) send_random_string(0, items);
  endtask

  // Sender waits for a fully drained block before the next string
  task automatic test_restart_after_drain();
    int items = 0;
    send_random_string(0, items);
    pause_until_drained();
    send_random_string(0, items);
  endtask

  // Take results at random, or hold off on request; check each one taken
  task automatic check_output(input b64d_pkg::out_item_t got);
    b64d_pkg::out_item_t want;
    if (decoded_q.size() == 0) begin
      $error("output with nothing pending: data_byte=%02h is_status=%0b",
             got.data_byte, got.is_status);
      mismatch_count++;
      return;
    end
    want = decoded_q.pop_front();
    outputs_checked++;
    if (got.data_byte !== want.data_byte) begin
      $error("data_byte: expected %02h, got %02h", want.data_byte, got.data_byte);
      mismatch_count++;
    end
    if (got.is_status !== want.is_status) begin
      $error("is_status: expected %0b, got %0b", want.is_status, got.is_status);
      mismatch_count++;
    end
    if (got.decode_ok !== want.decode_ok) begin
      $error("decode_ok: expected %0b, got %0b", want.decode_ok, got.decode_ok);
      mismatch_count++;
    end
    if (got.byte_count !== want.byte_count) begin
      $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
      mismatch_count++;
    end
    if (want.is_status) begin
      if (want.decode_ok) strings_ok++;
      else strings_bad++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) check_output(out_item);
      if (hold_acks != hold_reqs) begin
        hold_acks = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[base64_decoder_checked] ERROR");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 32;
    recv_idle_pct = 60;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_padding_rules();
    test_invalid_input();
    test_random_traffic(32, 60, 200);
    test_random_traffic(60, 32, 200);
    test_output_stall();
    test_restart_after_drain();
    test_random_traffic(0, 0, 180);

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d outputs over %0d strings (%0d valid, %0d rejected),",
             outputs_checked, strings_ok + strings_bad, strings_ok, strings_bad);
    $display("with padding, foreign codes, truncation and output stalls exercised.");
    if (mismatch_count == 0) begin
      $display("[base64_decoder_checked] OK");
    end else begin
      $display("[base64_decoder_checked] ERROR");
    end
    $finish;
  end

endmodule
